// ----- src/two_phase_advection_diffusion_sweep_macros.svh -----
// assertion macros shared by the two-phase advection-diffusion sweep rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef TWO_PHASE_ADVECTION_DIFFUSION_SWEEP_MACROS_SVH
`define TWO_PHASE_ADVECTION_DIFFUSION_SWEEP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TPAD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tpad assertion failed");
// next-cycle implication
`define TPAD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tpad assertion failed");
`else
`define TPAD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TPAD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/tpad_pkg.sv -----
// types, register codes and helpers for the two-phase advection-diffusion sweep
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tpad_pkg;

    localparam int IDX_W  = 7;
    localparam int GAIN_W = 24;
    localparam int TEMP_W = 32;
    localparam int FRAC_W = 24;
    localparam int CFG_IDX_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONV_GAIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAS_DIFF    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID_DIFF  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXCH_GAIN   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_INC     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_FIRST   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_LAST    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INLET_TEMP  = 4'd7;

    // register reset values
    localparam logic [GAIN_W-1:0]        RST_CONV_GAIN  = 24'd167772;
    localparam logic [GAIN_W-1:0]        RST_GAS_DIFF   = 24'd16777;
    localparam logic [GAIN_W-1:0]        RST_SOLID_DIFF = 24'd8389;
    localparam logic [GAIN_W-1:0]        RST_EXCH_GAIN  = 24'd83886;
    localparam logic signed [TEMP_W-1:0] RST_SRC_INC    = 32'sd20644;
    localparam logic [IDX_W-1:0]         RST_SRC_FIRST  = 7'd40;
    localparam logic [IDX_W-1:0]         RST_SRC_LAST   = 7'd60;
    localparam logic signed [TEMP_W-1:0] RST_INLET_TEMP = 32'sd983040;

    // command kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_INLET = 2'd1;
    localparam logic [1:0] KIND_NODE  = 2'd2;
    localparam logic [1:0] KIND_LAST  = 2'd3;

    typedef struct packed {
        logic signed [TEMP_W-1:0] gas_temp;
        logic signed [TEMP_W-1:0] solid_temp;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         node_index;
        logic signed [TEMP_W-1:0] new_gas_temp;
        logic signed [TEMP_W-1:0] new_solid_temp;
        logic                     sweep_end;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]        convection_gain;
        logic [GAIN_W-1:0]        gas_diffusion_gain;
        logic [GAIN_W-1:0]        solid_diffusion_gain;
        logic [GAIN_W-1:0]        exchange_gain;
        logic signed [TEMP_W-1:0] source_increment;
        logic [IDX_W-1:0]         source_first_node;
        logic [IDX_W-1:0]         source_last_node;
        logic signed [TEMP_W-1:0] inlet_temperature;
    } cfg_t;

    // queue entry: one node worth of work for the back end
    typedef struct packed {
        logic [1:0]               kind;
        logic [IDX_W-1:0]         index;
        logic                     add_src;
        logic signed [TEMP_W-1:0] gas;
        logic signed [TEMP_W-1:0] solid;
        logic signed [32:0]       d_conv;
        logic signed [34:0]       d_gas_lap;
        logic signed [32:0]       d_exch;
        logic signed [34:0]       d_solid_lap;
    } cmd_t;

    function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [38:0] x);
        logic signed [TEMP_W-1:0] r;
        if (x[38:31] != {8{x[38]}}) begin
            r = x[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/tpad_front.sv -----
// front end: node window, counter and classification into queue commands
// depends on tpad_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpad_front import tpad_pkg::*; #(
    parameter int NODES = 128
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    input  wire cfg_t      cfg,
    input  wire logic      q_full,
    output logic           q_push,
    output cmd_t           q_data
);

    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic signed [TEMP_W-1:0] gas_prev_reg, gas_cur_reg;
    logic signed [TEMP_W-1:0] solid_prev_reg, solid_cur_reg;
    logic                     accept;
    logic                     last;
    logic [IDX_W-1:0]         node_i;
    logic [1:0]               kind;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign last    = cnt_reg >= IDX_W'(NODES - 1);
    assign node_i  = cnt_reg - 7'd1;

    always_comb begin
        priority if (cnt_reg == '0) begin
            kind = KIND_INLET;
        end else if (last) begin
            kind = KIND_LAST;
        end else if (cnt_reg == 7'd1) begin
            kind = KIND_NONE;
        end else begin
            kind = KIND_NODE;
        end
    end

    always_comb begin
        q_data.kind        = kind;
        q_data.index       = (kind == KIND_INLET) ? '0 : node_i;
        q_data.add_src     = (node_i >= cfg.source_first_node)
                             && (node_i <= cfg.source_last_node);
        q_data.gas         = gas_cur_reg;
        q_data.solid       = solid_cur_reg;
        q_data.d_conv      = 33'(gas_prev_reg) - 33'(gas_cur_reg);
        q_data.d_gas_lap   = 35'(s_data.gas_temp) - (35'(gas_cur_reg) <<< 1)
                             + 35'(gas_prev_reg);
        q_data.d_exch      = 33'(solid_cur_reg) - 33'(gas_cur_reg);
        q_data.d_solid_lap = 35'(s_data.solid_temp) - (35'(solid_cur_reg) <<< 1)
                             + 35'(solid_prev_reg);
    end

    assign q_push = accept && (kind != KIND_NONE);

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = last ? '0 : cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gas_prev_reg   <= gas_cur_reg;
            gas_cur_reg    <= s_data.gas_temp;
            solid_prev_reg <= solid_cur_reg;
            solid_cur_reg  <= s_data.solid_temp;
        end
    end

endmodule

`default_nettype wire

// ----- src/tpad_queue.sv -----
// short command queue between front and back end, flip-flop storage
// depends on tpad_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "two_phase_advection_diffusion_sweep_macros.svh"

module tpad_queue import tpad_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TPAD_ASSERT_IMP(a_no_overflow, aclk, aresetn, push, !full)
    `TPAD_ASSERT_IMP(a_no_underflow, aclk, aresetn, pop, not_empty)

endmodule

`default_nettype wire

// ----- src/tpad_back.sv -----
// back end: gain products, node update sum with saturation, result register
// depends on tpad_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "two_phase_advection_diffusion_sweep_macros.svh"

module tpad_back import tpad_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire cmd_t  q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_data
);

    // product stage
    logic                     a_valid_reg, a_valid_next;
    logic [1:0]               a_kind_reg;
    logic [IDX_W-1:0]         a_index_reg;
    logic                     a_src_reg;
    logic signed [TEMP_W-1:0] a_gas_reg, a_solid_reg;
    logic signed [33:0]       a_t_conv_reg, a_t_exg_reg, a_t_exs_reg;
    logic signed [35:0]       a_t_gd_reg, a_t_sd_reg;

    logic signed [57:0]       p_conv, p_exg, p_exs;
    logic signed [59:0]       p_gd, p_sd;
    logic signed [32:0]       d_exch_neg;

    // result stage
    logic                     m_valid_reg, m_valid_next;
    logic                     dup_reg, dup_next;
    out_item_t                out_reg, out_next;
    logic signed [38:0]       gas_sum, solid_sum;
    logic signed [TEMP_W-1:0] src_term;
    logic                     out_free, a_adv, out_load, out_take;

    assign out_take = m_valid_reg && m_ready;
    assign out_free = !m_valid_reg || (m_ready && !dup_reg);
    assign out_load = a_valid_reg && out_free;
    assign a_adv    = !a_valid_reg || out_free;
    assign q_pop    = q_valid && a_adv;

    assign d_exch_neg = -q_data.d_exch;
    assign p_conv = $signed({1'b0, cfg.convection_gain}) * q_data.d_conv;
    assign p_gd   = $signed({1'b0, cfg.gas_diffusion_gain}) * q_data.d_gas_lap;
    assign p_exg  = $signed({1'b0, cfg.exchange_gain}) * q_data.d_exch;
    assign p_sd   = $signed({1'b0, cfg.solid_diffusion_gain}) * q_data.d_solid_lap;
    assign p_exs  = $signed({1'b0, cfg.exchange_gain}) * d_exch_neg;

    assign a_valid_next = a_adv ? q_valid : a_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    // floor of product over 2^24 is the upper part of the product
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_kind_reg   <= q_data.kind;
            a_index_reg  <= q_data.index;
            a_src_reg    <= q_data.add_src;
            a_gas_reg    <= q_data.gas;
            a_solid_reg  <= q_data.solid;
            a_t_conv_reg <= p_conv[57:FRAC_W];
            a_t_gd_reg   <= p_gd[59:FRAC_W];
            a_t_exg_reg  <= p_exg[57:FRAC_W];
            a_t_sd_reg   <= p_sd[59:FRAC_W];
            a_t_exs_reg  <= p_exs[57:FRAC_W];
        end
    end

    assign src_term  = a_src_reg ? cfg.source_increment : 32'sd0;
    assign gas_sum   = 39'(a_gas_reg) + 39'(a_t_conv_reg) + 39'(a_t_gd_reg)
                       + 39'(a_t_exg_reg) + 39'(src_term);
    assign solid_sum = 39'(a_solid_reg) + 39'(a_t_sd_reg) + 39'(a_t_exs_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        dup_next     = dup_reg;
        out_next     = out_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            out_next.node_index = a_index_reg;
            out_next.sweep_end  = 1'b0;
            if (a_kind_reg == KIND_INLET) begin
                out_next.new_gas_temp   = cfg.inlet_temperature;
                out_next.new_solid_temp = cfg.inlet_temperature;
                dup_next                = 1'b0;
            end else begin
                out_next.new_gas_temp   = sat_temp(gas_sum);
                out_next.new_solid_temp = sat_temp(solid_sum);
                dup_next                = (a_kind_reg == KIND_LAST);
            end
        end else if (out_take && dup_reg) begin
            // last node copies its neighbor
            out_next.node_index = out_reg.node_index + 7'd1;
            out_next.sweep_end  = 1'b1;
            dup_next            = 1'b0;
        end else if (out_take) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            dup_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            dup_reg     <= dup_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `TPAD_ASSERT_NXT(a_copy_follows, aclk, aresetn, out_take && dup_reg, m_valid && m_data.sweep_end)
    `TPAD_ASSERT_IMP(a_end_no_copy, aclk, aresetn, m_valid && m_data.sweep_end, !dup_reg)

endmodule

`default_nettype wire

// ----- src/two_phase_advection_diffusion_sweep.sv -----
// top level of the two-phase advection-diffusion sweep: config registers,
// front end, command queue and back end; depends on tpad_pkg and all tpad_ modules
//
//  channel  ports              direction  width  meaning
//  input    s_valid/s_ready    in         64     gas and solid temperature of next node
//  result   m_valid/m_ready    out        72     node index, new temperatures, end flag
//  config   cfg_wr_en          in         4+32   register write, no read-back
//
// one node per cycle in while the queue is not full; the final node of a sweep gives
// two results, held one after the other on the result register
// a result passes from the transfer that causes it through the queue write, then
// the product register, then the result register
// reset clears the node counter, queue and valid flags; no clearing pass
// the queue lets input keep flowing while a result is stalled, until it fills
`timescale 1ns / 1ps
`default_nettype none

module two_phase_advection_diffusion_sweep import tpad_pkg::*; #(
    parameter int NODES       = 128,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TEMP_W-1:0]    cfg_wdata
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_full, q_pop, q_not_empty;
    cmd_t q_in, q_out;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CONV_GAIN:  cfg_next.convection_gain      = cfg_wdata[GAIN_W-1:0];
                REG_GAS_DIFF:   cfg_next.gas_diffusion_gain   = cfg_wdata[GAIN_W-1:0];
                REG_SOLID_DIFF: cfg_next.solid_diffusion_gain = cfg_wdata[GAIN_W-1:0];
                REG_EXCH_GAIN:  cfg_next.exchange_gain        = cfg_wdata[GAIN_W-1:0];
                REG_SRC_INC:    cfg_next.source_increment     = cfg_wdata;
                REG_SRC_FIRST:  cfg_next.source_first_node    = cfg_wdata[IDX_W-1:0];
                REG_SRC_LAST:   cfg_next.source_last_node     = cfg_wdata[IDX_W-1:0];
                REG_INLET_TEMP: cfg_next.inlet_temperature    = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.convection_gain      <= RST_CONV_GAIN;
            cfg_reg.gas_diffusion_gain   <= RST_GAS_DIFF;
            cfg_reg.solid_diffusion_gain <= RST_SOLID_DIFF;
            cfg_reg.exchange_gain        <= RST_EXCH_GAIN;
            cfg_reg.source_increment     <= RST_SRC_INC;
            cfg_reg.source_first_node    <= RST_SRC_FIRST;
            cfg_reg.source_last_node     <= RST_SRC_LAST;
            cfg_reg.inlet_temperature    <= RST_INLET_TEMP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tpad_front #(
        .NODES (NODES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    tpad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    tpad_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/two_phase_advection_diffusion_sweep_tb.sv -----
`timescale 1ns / 1ps
// testbench for the two-phase advection-diffusion sweep: streams node temperatures under
// random handshake gaps and register settings and checks each result against a stencil model
// depends on tpad_pkg and the two_phase_advection_diffusion_sweep rtl

module two_phase_advection_diffusion_sweep_tb;
    import tpad_pkg::*;

    localparam int NODES         = 128;
    localparam int RANDOM_NODES  = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 32'sh8000_0000;
    localparam logic [GAIN_W-1:0]        GAIN_MAX = 24'hFF_FFFF;
    localparam longint                   ONE_DEG  = 65536;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;
    typedef enum int {SHAPE_PROFILE, SHAPE_NOISE, SHAPE_EXTREME} temp_shape_e;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TEMP_W-1:0]    cfg_wdata = '0;

    two_phase_advection_diffusion_sweep #(
        .NODES(NODES)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // stencil model state
    cfg_t        model_cfg;
    longint      gas_hist [2];
    longint      solid_hist [2];
    int unsigned sweep_pos;
    out_item_t   expected_nodes [$];
    int unsigned mismatches = 0;

    // stimulus state
    int unsigned nodes_sent = 0;
    int unsigned burst_left = 0;
    int unsigned max_gap    = 0;
    longint      gas_base, solid_base, gas_slope, solid_slope;

    rx_mode_e    rx_mode  = RX_ALWAYS;
    int unsigned rx_phase = 0;
    int unsigned rx_hold  = 0;

    function automatic void reset_model();
        model_cfg.convection_gain      = RST_CONV_GAIN;
        model_cfg.gas_diffusion_gain   = RST_GAS_DIFF;
        model_cfg.solid_diffusion_gain = RST_SOLID_DIFF;
        model_cfg.exchange_gain        = RST_EXCH_GAIN;
        model_cfg.source_increment     = RST_SRC_INC;
        model_cfg.source_first_node    = RST_SRC_FIRST;
        model_cfg.source_last_node     = RST_SRC_LAST;
        model_cfg.inlet_temperature    = RST_INLET_TEMP;
        gas_hist   = '{0, 0};
        solid_hist = '{0, 0};
        sweep_pos  = 0;
    endfunction

    function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [TEMP_W-1:0] word);
        case (idx)
            REG_CONV_GAIN:  model_cfg.convection_gain      = word[GAIN_W-1:0];
            REG_GAS_DIFF:   model_cfg.gas_diffusion_gain   = word[GAIN_W-1:0];
            REG_SOLID_DIFF: model_cfg.solid_diffusion_gain = word[GAIN_W-1:0];
            REG_EXCH_GAIN:  model_cfg.exchange_gain        = word[GAIN_W-1:0];
            REG_SRC_INC:    model_cfg.source_increment     = word;
            REG_SRC_FIRST:  model_cfg.source_first_node    = word[IDX_W-1:0];
            REG_SRC_LAST:   model_cfg.source_last_node     = word[IDX_W-1:0];
            REG_INLET_TEMP: model_cfg.inlet_temperature    = word;
            default: ;
        endcase
    endfunction

    // gain times difference, floored by dropping the fraction bits
    function automatic longint scaled_term(input logic [GAIN_W-1:0] gain, input longint diff);
        longint gain_l;
        gain_l = longint'(gain);
        return (gain_l * diff) >>> FRAC_W;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp_temp(input longint x);
        if (x > longint'(TEMP_MAX))
            return TEMP_MAX;
        if (x < longint'(TEMP_MIN))
            return TEMP_MIN;
        return x[TEMP_W-1:0];
    endfunction

    function automatic void predict_node(input in_item_t item);
        longint      g_next, s_next, g_prev, g_mid, s_prev, s_mid, g_new, s_new;
        int unsigned node;
        logic        at_last;
        out_item_t   res;
        g_next  = $signed(item.gas_temp);
        s_next  = $signed(item.solid_temp);
        at_last = (sweep_pos >= NODES - 1);
        if (sweep_pos == 0) begin
            res.node_index     = '0;
            res.new_gas_temp   = model_cfg.inlet_temperature;
            res.new_solid_temp = model_cfg.inlet_temperature;
            res.sweep_end      = 1'b0;
            expected_nodes.push_back(res);
        end else if (sweep_pos >= 2) begin
            node   = sweep_pos - 1;
            g_prev = gas_hist[0];
            g_mid  = gas_hist[1];
            s_prev = solid_hist[0];
            s_mid  = solid_hist[1];
            g_new  = g_mid
                   + scaled_term(model_cfg.convection_gain, g_prev - g_mid)
                   + scaled_term(model_cfg.gas_diffusion_gain, g_next - 2 * g_mid + g_prev)
                   + scaled_term(model_cfg.exchange_gain, s_mid - g_mid);
            s_new  = s_mid
                   + scaled_term(model_cfg.solid_diffusion_gain, s_next - 2 * s_mid + s_prev)
                   + scaled_term(model_cfg.exchange_gain, g_mid - s_mid);
            if (node >= model_cfg.source_first_node && node <= model_cfg.source_last_node)
                g_new = g_new + longint'($signed(model_cfg.source_increment));
            res.node_index     = node[IDX_W-1:0];
            res.new_gas_temp   = clamp_temp(g_new);
            res.new_solid_temp = clamp_temp(s_new);
            res.sweep_end      = 1'b0;
            expected_nodes.push_back(res);
            if (at_last) begin
                res.node_index = sweep_pos[IDX_W-1:0];
                res.sweep_end  = 1'b1;
                expected_nodes.push_back(res);
            end
        end
        gas_hist[0]   = gas_hist[1];
        gas_hist[1]   = g_next;
        solid_hist[0] = solid_hist[1];
        solid_hist[1] = s_next;
        sweep_pos     = at_last ? 0 : sweep_pos + 1;
    endfunction

    always @(posedge aclk) begin : scoreboard
        out_item_t want;
        if (aresetn) begin
            if (cfg_wr_en)
                store_register(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                predict_node(s_data);
            if (m_valid && m_ready) begin
                if (expected_nodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: node %0d gas %0d solid %0d end %0b",
                                 m_data.node_index, m_data.new_gas_temp,
                                 m_data.new_solid_temp, m_data.sweep_end);
                end else begin
                    want = expected_nodes.pop_front();
                    if (m_data.node_index !== want.node_index
                            || m_data.new_gas_temp !== want.new_gas_temp
                            || m_data.new_solid_temp !== want.new_solid_temp
                            || m_data.sweep_end !== want.sweep_end) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected node %0d gas %0d solid %0d end %0b, %s",
                                     want.node_index, want.new_gas_temp, want.new_solid_temp,
                                     want.sweep_end,
                                     $sformatf("got node %0d gas %0d solid %0d end %0b",
                                               m_data.node_index, m_data.new_gas_temp,
                                               m_data.new_solid_temp, m_data.sweep_end));
                    end
                end
            end
        end
    end

    // result side stall pattern
    always @(posedge aclk) begin
        case (rx_mode)
            RX_ALWAYS: m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 99) < 60);
            RX_PERIODIC: begin
                rx_phase <= (rx_phase + 1) % 7;
                m_ready  <= (rx_phase < 4);
            end
            default: begin
                if (rx_hold != 0) begin
                    rx_hold <= rx_hold - 1;
                end else begin
                    m_ready <= ~m_ready;
                    rx_hold <= m_ready ? $urandom_range(4, 16) : $urandom_range(1, 6);
                end
            end
        endcase
    end

    task automatic apply_reset();
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic send_node(input in_item_t item);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TEMP_W-1:0] word);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // wait until every expected result has come and the pipeline has emptied
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_nodes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic in_item_t node_item(input logic signed [TEMP_W-1:0] g,
                                           input logic signed [TEMP_W-1:0] s);
        in_item_t item;
        item.gas_temp   = g;
        item.solid_temp = s;
        return item;
    endfunction

    // unused upper bits of the write word carry random data
    function automatic logic [TEMP_W-1:0] pad_gain(input logic [GAIN_W-1:0] g);
        return {8'($urandom), g};
    endfunction

    function automatic logic [TEMP_W-1:0] pad_index(input logic [IDX_W-1:0] n);
        return {25'($urandom), n};
    endfunction

    function automatic logic signed [TEMP_W-1:0] extreme_temp();
        case ($urandom_range(0, 5))
            0: return TEMP_MAX;
            1: return TEMP_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return GAIN_MAX;
            2: return 24'($urandom_range(0, 1 << 19));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [TEMP_W-1:0] pick_temp_word();
        case ($urandom_range(0, 2))
            0: return extreme_temp();
            1: return clamp_temp((longint'($urandom_range(0, 800)) - 400) * ONE_DEG);
            default: return $urandom;
        endcase
    endfunction

    function automatic longint temp_noise();
        return longint'($urandom_range(0, 8191)) - 4096;
    endfunction

    function automatic void new_profile();
        gas_base    = (longint'($urandom_range(0, 800)) - 400) * ONE_DEG;
        solid_base  = (longint'($urandom_range(0, 800)) - 400) * ONE_DEG;
        gas_slope   = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
        solid_slope = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    function automatic in_item_t make_node(input temp_shape_e shape);
        in_item_t item;
        longint   pos;
        pos = longint'(nodes_sent % NODES);
        case (shape)
            SHAPE_PROFILE: begin
                item.gas_temp   = clamp_temp(gas_base + gas_slope * pos + temp_noise());
                item.solid_temp = clamp_temp(solid_base + solid_slope * pos + temp_noise());
            end
            SHAPE_NOISE: begin
                item.gas_temp   = $urandom;
                item.solid_temp = $urandom;
            end
            default: begin
                item.gas_temp   = extreme_temp();
                item.solid_temp = extreme_temp();
            end
        endcase
        return item;
    endfunction

    function automatic temp_shape_e pick_shape();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return SHAPE_PROFILE;
        if (r < 92)
            return SHAPE_NOISE;
        return SHAPE_EXTREME;
    endfunction

    task automatic run_nodes(input int unsigned count);
        repeat (count) begin
            send_node(make_node(pick_shape()));
            nodes_sent++;
        end
    endtask

    task automatic shuffle_idling();
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
            0: max_gap = 0;
            1: max_gap = 3;
            default: max_gap = 12;
        endcase
    endtask

    task automatic randomize_registers();
        write_register(REG_CONV_GAIN,  pad_gain(pick_gain()));
        write_register(REG_GAS_DIFF,   pad_gain(pick_gain()));
        write_register(REG_SOLID_DIFF, pad_gain(pick_gain()));
        write_register(REG_EXCH_GAIN,  pad_gain(pick_gain()));
        write_register(REG_SRC_INC,    pick_temp_word());
        write_register(REG_SRC_FIRST,  pad_index(7'($urandom)));
        write_register(REG_SRC_LAST,   pad_index(7'($urandom)));
        write_register(REG_INLET_TEMP, pick_temp_word());
    endtask

    // reset register values with field extremes and saturating curvature
    task automatic test_reset_values();
        rx_mode = RX_COIN;
        max_gap = 3;
        send_node(node_item(TEMP_MAX, TEMP_MIN));
        send_node(node_item(TEMP_MIN, TEMP_MAX));
        send_node(node_item(TEMP_MAX, TEMP_MIN));
        send_node(node_item(32'sd0, -32'sd1));
        send_node(node_item(-32'sd1, 32'sd0));
        send_node(node_item(32'sd1, 32'sd1));
        settle();
    endtask

    // all gains at full scale, then all gains zero
    task automatic test_gain_extremes();
        write_register(REG_CONV_GAIN,  pad_gain(GAIN_MAX));
        write_register(REG_GAS_DIFF,   pad_gain(GAIN_MAX));
        write_register(REG_SOLID_DIFF, pad_gain(GAIN_MAX));
        write_register(REG_EXCH_GAIN,  pad_gain(GAIN_MAX));
        write_register(REG_SRC_INC,    TEMP_MAX);
        write_register(REG_SRC_FIRST,  pad_index(7'd0));
        write_register(REG_SRC_LAST,   pad_index(7'(NODES - 1)));
        write_register(REG_INLET_TEMP, TEMP_MIN);
        send_node(node_item(TEMP_MIN, TEMP_MAX));
        send_node(node_item(TEMP_MAX, TEMP_MIN));
        send_node(node_item(TEMP_MIN, TEMP_MAX));
        send_node(node_item(TEMP_MAX, TEMP_MAX));
        send_node(node_item(TEMP_MIN, TEMP_MIN));
        send_node(node_item(32'sd0, 32'sd0));
        settle();
        write_register(REG_CONV_GAIN,  pad_gain('0));
        write_register(REG_GAS_DIFF,   pad_gain('0));
        write_register(REG_SOLID_DIFF, pad_gain('0));
        write_register(REG_EXCH_GAIN,  pad_gain('0));
        write_register(REG_SRC_INC,    TEMP_MIN);
        write_register(REG_INLET_TEMP, TEMP_MAX);
        send_node(node_item(TEMP_MAX, TEMP_MIN));
        send_node(node_item(TEMP_MIN, TEMP_MAX));
        send_node(node_item(-32'sd1, 32'sd1));
        send_node(node_item(32'sd1, -32'sd1));
        settle();
    endtask

    // writes above the last register index must not disturb anything
    task automatic test_register_index_out_of_range();
        for (int k = int'(REG_INLET_TEMP) + 1; k < (1 << CFG_IDX_W); k++)
            write_register(CFG_IDX_W'(k), $urandom);
        send_node(node_item(32'sd20 * 32'(ONE_DEG), 32'sd10 * 32'(ONE_DEG)));
        send_node(node_item(32'sd25 * 32'(ONE_DEG), 32'sd12 * 32'(ONE_DEG)));
        send_node(node_item(32'sd22 * 32'(ONE_DEG), 32'sd11 * 32'(ONE_DEG)));
        send_node(node_item(32'sd18 * 32'(ONE_DEG), 32'sd9 * 32'(ONE_DEG)));
        settle();
    endtask

    // source range over both boundaries, empty range, and only the node before the last
    task automatic test_source_range_edges();
        logic [IDX_W-1:0] first_nodes [3];
        logic [IDX_W-1:0] last_nodes [3];
        first_nodes = '{7'd0, 7'd90, 7'(NODES - 2)};
        last_nodes  = '{7'(NODES - 1), 7'd30, 7'(NODES - 2)};
        for (int k = 0; k < 3; k++) begin
            randomize_registers();
            write_register(REG_SRC_INC, 32'sd5 * 32'(ONE_DEG));
            write_register(REG_SRC_FIRST, pad_index(first_nodes[k]));
            write_register(REG_SRC_LAST, pad_index(last_nodes[k]));
            shuffle_idling();
            new_profile();
            run_nodes(NODES - sweep_pos);
            settle();
        end
    endtask

    task automatic test_random_sweeps();
        while (nodes_sent < RANDOM_NODES) begin
            if ($urandom_range(0, 9) < 7)
                randomize_registers();
            shuffle_idling();
            new_profile();
            if ($urandom_range(0, 9) < 6)
                run_nodes(NODES - sweep_pos);
            else
                run_nodes($urandom_range(1, 200));
            settle();
        end
    endtask

    initial begin
        reset_model();
        new_profile();
        apply_reset();
        test_reset_values();
        test_gain_extremes();
        test_register_index_out_of_range();
        test_source_range_edges();
        test_random_sweeps();
        if (mismatches == 0 && expected_nodes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
